@@ sv/med_pkg.sv @@
`default_nettype none

package med_pkg;

    // Width of the stored element count and of the pause counter
    localparam int LEN_W   = 4;
    localparam int TICKS_W = 4;
    // Elements held by the ROM key; longer shapes never match
    localparam int KEY_BITS = 7;
    // Widest stored pattern the block supports
    localparam int PAT_MAX_W = 15;
    // Count, flag, counter and closed bit stored next to the pattern
    localparam int STATE_EXTRA_W = LEN_W + 1 + TICKS_W + 1;

    localparam logic [3:0] GAP_RESET    = 4'd4;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_UNKNOWN = 8'h00;

    typedef enum logic [1:0] {
        ELEM_PAUSE = 2'd0,
        ELEM_DIT   = 2'd1,
        ELEM_DAH   = 2'd2,
        ELEM_NONE  = 2'd3
    } elem_t;

    typedef enum logic [1:0] {
        KIND_ECHO    = 2'd0,
        KIND_CHAR    = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_SPACE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] code;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
    } rom_hit_t;

    // Morse ROM: element i at bit i, 1 = dah. Shapes repeated later in the
    // table (the asterisk shares the plus shape) are left out.
    function automatic rom_hit_t rom_lookup(input logic [LEN_W-1:0] len,
                                            input logic [KEY_BITS-1:0] bits);
        rom_hit_t r;
        r.hit  = 1'b1;
        r.code = CHAR_UNKNOWN;
        case ({len, bits})
            {4'd2, 7'b0000010}: r.code = 8'h41; // A
            {4'd4, 7'b0000001}: r.code = 8'h42; // B
            {4'd4, 7'b0000101}: r.code = 8'h43; // C
            {4'd3, 7'b0000001}: r.code = 8'h44; // D
            {4'd1, 7'b0000000}: r.code = 8'h45; // E
            {4'd4, 7'b0000100}: r.code = 8'h46; // F
            {4'd3, 7'b0000011}: r.code = 8'h47; // G
            {4'd4, 7'b0000000}: r.code = 8'h48; // H
            {4'd2, 7'b0000000}: r.code = 8'h49; // I
            {4'd4, 7'b0001110}: r.code = 8'h4A; // J
            {4'd3, 7'b0000101}: r.code = 8'h4B; // K
            {4'd4, 7'b0000010}: r.code = 8'h4C; // L
            {4'd2, 7'b0000011}: r.code = 8'h4D; // M
            {4'd2, 7'b0000001}: r.code = 8'h4E; // N
            {4'd3, 7'b0000111}: r.code = 8'h4F; // O
            {4'd4, 7'b0000110}: r.code = 8'h50; // P
            {4'd4, 7'b0001011}: r.code = 8'h51; // Q
            {4'd3, 7'b0000010}: r.code = 8'h52; // R
            {4'd3, 7'b0000000}: r.code = 8'h53; // S
            {4'd1, 7'b0000001}: r.code = 8'h54; // T
            {4'd3, 7'b0000100}: r.code = 8'h55; // U
            {4'd4, 7'b0001000}: r.code = 8'h56; // V
            {4'd3, 7'b0000110}: r.code = 8'h57; // W
            {4'd4, 7'b0001001}: r.code = 8'h58; // X
            {4'd4, 7'b0001101}: r.code = 8'h59; // Y
            {4'd4, 7'b0000011}: r.code = 8'h5A; // Z
            {4'd5, 7'b0011111}: r.code = 8'h30; // 0
            {4'd5, 7'b0011110}: r.code = 8'h31; // 1
            {4'd5, 7'b0011100}: r.code = 8'h32; // 2
            {4'd5, 7'b0011000}: r.code = 8'h33; // 3
            {4'd5, 7'b0010000}: r.code = 8'h34; // 4
            {4'd5, 7'b0000000}: r.code = 8'h35; // 5
            {4'd5, 7'b0000001}: r.code = 8'h36; // 6
            {4'd5, 7'b0000011}: r.code = 8'h37; // 7
            {4'd5, 7'b0000111}: r.code = 8'h38; // 8
            {4'd5, 7'b0001111}: r.code = 8'h39; // 9
            {4'd6, 7'b0010010}: r.code = 8'h22; // double quote
            {4'd6, 7'b0011110}: r.code = 8'h27; // apostrophe
            {4'd7, 7'b1001000}: r.code = 8'h24; // dollar
            {4'd5, 7'b0001101}: r.code = 8'h28; // open paren
            {4'd6, 7'b0101101}: r.code = 8'h29; // close paren
            {4'd5, 7'b0001010}: r.code = 8'h2B; // plus
            {4'd6, 7'b0110011}: r.code = 8'h2C; // comma
            {4'd6, 7'b0100001}: r.code = 8'h2D; // hyphen
            {4'd6, 7'b0101010}: r.code = 8'h2E; // period
            {4'd5, 7'b0001001}: r.code = 8'h2F; // slash
            {4'd6, 7'b0000111}: r.code = 8'h3A; // colon
            {4'd6, 7'b0010101}: r.code = 8'h3B; // semicolon
            {4'd5, 7'b0010001}: r.code = 8'h3D; // equals
            {4'd6, 7'b0001100}: r.code = 8'h3F; // question mark
            {4'd6, 7'b0101100}: r.code = 8'h5F; // underscore
            {4'd6, 7'b0010110}: r.code = 8'h40; // at sign
            {4'd6, 7'b0101000}: r.code = 8'h3C; // end of work prosign
            {4'd7, 7'b1010001}: r.code = 8'h3E; // end of contact prosign
            {4'd5, 7'b0001000}: r.code = 8'h21; // understood prosign
            {4'd5, 7'b0000010}: r.code = 8'h26; // wait prosign
            {4'd4, 7'b0001100}: r.code = 8'hDC; // U umlaut
            {4'd4, 7'b0001010}: r.code = 8'hC4; // A umlaut
            {4'd5, 7'b0000101}: r.code = 8'hC7; // C cedilla
            {4'd4, 7'b0000111}: r.code = 8'hD6; // O umlaut
            {4'd5, 7'b0000100}: r.code = 8'hC9; // E acute
            {4'd5, 7'b0010010}: r.code = 8'hC8; // E grave
            {4'd5, 7'b0010110}: r.code = 8'hC0; // A grave
            {4'd5, 7'b0011011}: r.code = 8'hD1; // N tilde
            {4'd4, 7'b0001111}: r.code = 8'hAA; // ch
            {4'd5, 7'b0010011}: r.code = 8'hAE; // reserved shape
            default:            r.hit  = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/med_state_ram.sv @@
`default_nettype none

// One-entry state store with a registered read port. The entry reads as
// zero until its first write.
module med_state_ram #(
    parameter int W = 17
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    input  wire logic         rd_en,
    output logic      [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [1];
    logic         written_reg;
    logic [W-1:0] rd_data_reg;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[0] <= wr_data;
        end
    end

    // Track whether the entry holds data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            written_reg <= 1'b1;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= written_reg ? mem_reg[0] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ sv/med_step.sv @@
`default_nettype none

// Next-state and result logic for one keyed element.
module med_step #(
    parameter int MAX_ELEMENTS = 7
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire logic [MAX_ELEMENTS+med_pkg::STATE_EXTRA_W-1:0] state_in,
    input  wire med_pkg::elem_t                                element,
    input  wire logic                                          cfg_wr_en,
    input  wire logic [3:0]                                    cfg_wr_data,
    output logic      [MAX_ELEMENTS+med_pkg::STATE_EXTRA_W-1:0] state_out,
    output med_pkg::result_t                                   res
);

    localparam int LEN_LO    = MAX_ELEMENTS;
    localparam int OVF_POS   = LEN_LO + med_pkg::LEN_W;
    localparam int TICKS_LO  = OVF_POS + 1;
    localparam int CLOSE_POS = TICKS_LO + med_pkg::TICKS_W;

    logic [3:0]                    gap_reg;
    logic [3:0]                    gap_eff;
    logic [MAX_ELEMENTS-1:0]       bits;
    logic [med_pkg::LEN_W-1:0]     len;
    logic                          ovf;
    logic [med_pkg::TICKS_W-1:0]   ticks;
    logic                          closed;
    logic [MAX_ELEMENTS-1:0]       bits_n;
    logic [med_pkg::LEN_W-1:0]     len_n;
    logic                          ovf_n;
    logic [med_pkg::TICKS_W-1:0]   ticks_n;
    logic                          closed_n;
    logic [med_pkg::PAT_MAX_W-1:0] bits_wide;
    med_pkg::rom_hit_t             hit;

    // Hold the word gap setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= med_pkg::GAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            gap_reg <= cfg_wr_data;
        end
    end

    assign gap_eff = (gap_reg == 4'd0) ? 4'd1 : gap_reg;

    // Split the stored state
    assign bits   = state_in[LEN_LO-1:0];
    assign len    = state_in[OVF_POS-1:LEN_LO];
    assign ovf    = state_in[OVF_POS];
    assign ticks  = state_in[CLOSE_POS-1:TICKS_LO];
    assign closed = state_in[CLOSE_POS];

    // Look the pattern up
    assign bits_wide = med_pkg::PAT_MAX_W'(bits);
    assign hit       = med_pkg::rom_lookup(len, bits_wide[med_pkg::KEY_BITS-1:0]);

    // Advance the state and form the result
    always_comb
    begin
        bits_n   = bits;
        len_n    = len;
        ovf_n    = ovf;
        ticks_n  = ticks;
        closed_n = closed;
        res      = '{valid: 1'b0, kind: med_pkg::KIND_ECHO, code: 8'h00};
        case (element)
            med_pkg::ELEM_DIT, med_pkg::ELEM_DAH:
            begin
                closed_n = 1'b0;
                ticks_n  = '0;
                if (len < med_pkg::LEN_W'(MAX_ELEMENTS))
                begin
                    for (int i = 0; i < MAX_ELEMENTS; i++)
                    begin
                        if ((len == med_pkg::LEN_W'(i)) && (element == med_pkg::ELEM_DAH))
                        begin
                            bits_n[i] = 1'b1;
                        end
                    end
                    len_n = len + 1'b1;
                end
                else
                begin
                    ovf_n = 1'b1;
                end
                res.valid = 1'b1;
                res.kind  = med_pkg::KIND_ECHO;
                res.code  = (element == med_pkg::ELEM_DAH) ? med_pkg::CHAR_DASH
                                                           : med_pkg::CHAR_DOT;
            end
            med_pkg::ELEM_PAUSE:
            begin
                if (!closed)
                begin
                    // Close the character on the first pause
                    if (ticks == '0)
                    begin
                        if ((len != '0) || ovf)
                        begin
                            res.valid = 1'b1;
                            if (!ovf && hit.hit)
                            begin
                                res.kind = med_pkg::KIND_CHAR;
                                res.code = hit.code;
                            end
                            else
                            begin
                                res.kind = med_pkg::KIND_UNKNOWN;
                                res.code = med_pkg::CHAR_UNKNOWN;
                            end
                        end
                        bits_n = '0;
                        len_n  = '0;
                        ovf_n  = 1'b0;
                    end
                    // Count the pause, saturating
                    if (ticks != '1)
                    begin
                        ticks_n = ticks + 1'b1;
                    end
                    // Close the word once the gap is exceeded
                    if (ticks >= gap_eff)
                    begin
                        closed_n = 1'b1;
                        if (!res.valid)
                        begin
                            res.valid = 1'b1;
                            res.kind  = med_pkg::KIND_SPACE;
                            res.code  = med_pkg::CHAR_SPACE;
                        end
                    end
                end
            end
            default:
            begin
                res.valid = 1'b0;
            end
        endcase
    end

    assign state_out = {closed_n, ticks_n, ovf_n, len_n, bits_n};

endmodule

`default_nettype wire

@@ sv/morse_element_decoder_unit.sv @@
// Morse element decoder.
// Input items on s_axis carry one keyed element each (pause tick, dit or
// dah). Each item gives zero or one result item on m_axis: an echo of a
// dit or dah, a decoded character, an unknown marker, or a word space.
// cfg_wr_en/cfg_wr_data load the word gap (pause ticks beyond which a
// word space goes out); write it only while the block is idle.
// An accepted item's element and stored state are registered at the
// accepting edge; the update stage then loads its result into the output
// register, waiting while that register is full and m_axis stalls.
// Throughput: one item per cycle while m_axis does not stall. The decoder
// state sits in a one-entry memory read ahead of its update; the value
// written in the cycle of that read is forwarded to the update stage, so
// items may follow each other back to back.
// Reset clears the stored pattern, counters and flags (the state reads as
// zero until first written) and sets the word gap to 4.
// When m_axis stalls, the output register holds its item; an item with a
// result then waits in the update stage, and s_axis_tready drops only
// when both are full. Items that give no result never wait on m_axis.
`default_nettype none

module morse_element_decoder_unit #(
    parameter int MAX_ELEMENTS = 7
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // tdata: element [1:0], zero fill [7:2]
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    // tdata: char_code [7:0]
    output logic      [7:0] m_axis_tdata,
    // tuser: result_kind [1:0]
    output logic      [1:0] m_axis_tuser,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    input  wire logic       cfg_wr_en,
    input  wire logic [3:0] cfg_wr_data
);

    localparam int STATE_W = MAX_ELEMENTS + med_pkg::STATE_EXTRA_W;

    logic                 accept;
    logic                 upd_go;
    logic                 upd_valid_reg;
    logic                 upd_valid_next;
    med_pkg::elem_t       elem_reg;
    logic                 fwd_reg;
    logic [STATE_W-1:0]   wdata_reg;
    logic [STATE_W-1:0]   rd_state;
    logic [STATE_W-1:0]   cur_state;
    logic [STATE_W-1:0]   state_next;
    med_pkg::result_t     res;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_code_reg;
    med_pkg::kind_t       out_kind_reg;

    // Advance the update stage unless its result cannot be placed
    assign upd_go        = upd_valid_reg && (!res.valid || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !upd_valid_reg || upd_go;
    assign accept        = s_axis_tvalid && s_axis_tready;

    med_state_ram #(
        .W (STATE_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (upd_go),
        .wr_data (state_next),
        .rd_en   (accept),
        .rd_data (rd_state)
    );

    // Forward the state written in the cycle of the read
    assign cur_state = fwd_reg ? wdata_reg : rd_state;

    med_step #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .state_in    (cur_state),
        .element     (elem_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .state_out   (state_next),
        .res         (res)
    );

    // Track the update stage occupancy
    always_comb
    begin
        upd_valid_next = upd_valid_reg;
        if (accept)
        begin
            upd_valid_next = 1'b1;
        end
        else if (upd_go)
        begin
            upd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end
        else
        begin
            upd_valid_reg <= upd_valid_next;
            if (accept)
            begin
                fwd_reg <= upd_go;
            end
        end
    end

    // Capture the item and the last written state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            elem_reg <= med_pkg::elem_t'(s_axis_tdata[1:0]);
        end
        if (upd_go)
        begin
            wdata_reg <= state_next;
        end
    end

    // Hold a result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (upd_go && res.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_go && res.valid)
        begin
            out_code_reg <= res.code;
            out_kind_reg <= res.kind;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_code_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule

`default_nettype wire
